// File: design/scpc_pkg.sv
// Shared types and constants for the Sattolo cycle pointer chase block.
package scpc_pkg;

   localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

   localparam int MIX_SHIFT_A = 30;
   localparam int MIX_SHIFT_B = 27;
   localparam int MIX_SHIFT_C = 31;

   localparam int ACCESS_W   = 32;
   localparam int CHECKSUM_W = 64;
   localparam int FINAL_W    = 12;
   localparam int NCOUNT_W   = 13;
   localparam int SEED_W     = 64;
   localparam int CSR_IDX_W  = 8;
   localparam int RSP_DATA_W = 80;

   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEED_VALUE = 8'd1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FILL,
      ST_RNG,
      ST_MIX1,
      ST_MIX1_WAIT,
      ST_MIX2,
      ST_MIX2_WAIT,
      ST_MOD,
      ST_MOD_WAIT,
      ST_SWAP_RD,
      ST_SWAP_WR1,
      ST_SWAP_WR2,
      ST_LAP_DIV,
      ST_LAP_DIV_WAIT,
      ST_LSUM,
      ST_LSUM_WAIT,
      ST_TOTAL,
      ST_TOTAL_WAIT,
      ST_CHASE_RD,
      ST_CHASE_ACC,
      ST_OUT
   } state_type;

endpackage

// File: design/sattolo_cycle_pointer_chase_top.sv
// Top level: sequencer, node table and result register of the pointer chase.
//
// Each request transfer carries an access count. The block fills the node
// table with the identity, runs Sattolo's shuffle driven by splitmix64 (seed
// zero taken as one) to form one cycle over all nodes, then chases pointers
// from index 0 and returns the wrapped sum of visited indices and the last
// index. Whole laps are added as laps * n(n-1)/2 and only the remainder is
// walked. The run time of a request is set mostly by the shuffle loop,
// where each step runs two multiplies and a bit-serial modulo through
// the shared units and a swap on the node table port. The block takes
// one request at a time; a finished result waits in the output register
// while the next request is already accepted.
// The node table needs no clearing pass: every entry used is written first.
module sattolo_cycle_pointer_chase_top #(
   parameter int MAX_NODES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = access_count[31:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // result: tdata = checksum[63:0], final_index[75:64], zero pad [79:76]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [scpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [scpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0] csr_data
);
   import scpc_pkg::*;

   localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int NW = $clog2(MAX_NODES + 1);

   // configuration
   logic [NCOUNT_W-1:0] ncount_ff;
   logic [SEED_W-1:0]   seed_ff;

   // sequencer state
   state_type           state_ff, state_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [ACCESS_W-1:0] acc_ff, acc_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       i_ff, i_in;
   logic [AW-1:0]       j_ff, j_in;
   logic [63:0]         rng_ff, rng_in;
   logic [31:0]         laps_ff, laps_in;
   logic [NW-1:0]       rest_ff, rest_in;
   logic [63:0]         sum_ff, sum_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // node table
   logic [AW-1:0] mem [MAX_NODES];
   logic          we;
   logic [AW-1:0] wa, wd, ra, rb;
   logic [AW-1:0] rd_a_ff, rd_b_ff;

   // shared units
   logic          mul_start, mul_done;
   logic [63:0]   mul_a, mul_b, mul_p;
   logic          div_start, div_done;
   logic [63:0]   div_n, div_q;
   logic [NW-1:0] div_d, div_r;

   logic [31:0]   ncount32;
   logic [NW-1:0] n_eff;
   logic [31:0]   idx32;

   scpc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   scpc_div #(.DW(NW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // saturate node count into [2, MAX_NODES]
   always_comb begin
      ncount32 = 32'(ncount_ff);
      if (ncount32 < 32'd2) begin
         n_eff = NW'(2);
      end else if (ncount32 > 32'(MAX_NODES)) begin
         n_eff = NW'(MAX_NODES);
      end else begin
         n_eff = NW'(ncount32);
      end
   end

   assign idx32 = 32'(idx_ff);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rng_in       = rng_ff;
      laps_in      = laps_ff;
      rest_in      = rest_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;
      we           = 1'b0;
      wa           = cnt_ff;
      wd           = cnt_ff;
      ra           = i_ff;
      rb           = j_ff;
      mul_start    = 1'b0;
      mul_a        = 64'd0;
      mul_b        = 64'd0;
      div_start    = 1'b0;
      div_n        = 64'd0;
      div_d        = n_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               acc_in   = req_tdata;
               n_in     = n_eff;
               cnt_in   = '0;
               rng_in   = (seed_ff != 64'd0) ? seed_ff : 64'd1;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            // write the identity, one entry a cycle
            we = 1'b1;
            if (NW'(cnt_ff) == n_ff - NW'(1)) begin
               i_in     = AW'(n_ff - NW'(1));
               state_in = ST_RNG;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_RNG: begin
            rng_in   = rng_ff + GOLDEN_INC;
            state_in = ST_MIX1;
         end
         ST_MIX1: begin
            mul_start = 1'b1;
            mul_a     = rng_ff ^ (rng_ff >> MIX_SHIFT_A);
            mul_b     = MIX_MUL_A;
            state_in  = ST_MIX1_WAIT;
         end
         ST_MIX1_WAIT: begin
            if (mul_done) state_in = ST_MIX2;
         end
         ST_MIX2: begin
            mul_start = 1'b1;
            mul_a     = mul_p ^ (mul_p >> MIX_SHIFT_B);
            mul_b     = MIX_MUL_B;
            state_in  = ST_MIX2_WAIT;
         end
         ST_MIX2_WAIT: begin
            if (mul_done) state_in = ST_MOD;
         end
         ST_MOD: begin
            div_start = 1'b1;
            div_n     = mul_p ^ (mul_p >> MIX_SHIFT_C);
            div_d     = NW'(i_ff);
            state_in  = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (div_done) begin
               j_in     = AW'(div_r);
               state_in = ST_SWAP_RD;
            end
         end
         ST_SWAP_RD: begin
            // read both entries; data lands in rd_a_ff / rd_b_ff
            ra       = i_ff;
            rb       = j_ff;
            state_in = ST_SWAP_WR1;
         end
         ST_SWAP_WR1: begin
            we       = 1'b1;
            wa       = i_ff;
            wd       = rd_b_ff;
            state_in = ST_SWAP_WR2;
         end
         ST_SWAP_WR2: begin
            we = 1'b1;
            wa = j_ff;
            wd = rd_a_ff;
            if (i_ff == AW'(1)) begin
               state_in = ST_LAP_DIV;
            end else begin
               i_in     = i_ff - AW'(1);
               state_in = ST_RNG;
            end
         end
         ST_LAP_DIV: begin
            div_start = 1'b1;
            div_n     = 64'(acc_ff);
            div_d     = n_ff;
            state_in  = ST_LAP_DIV_WAIT;
         end
         ST_LAP_DIV_WAIT: begin
            if (div_done) begin
               laps_in  = div_q[31:0];
               rest_in  = div_r;
               state_in = ST_LSUM;
            end
         end
         ST_LSUM: begin
            mul_start = 1'b1;
            mul_a     = 64'(n_ff);
            mul_b     = 64'(n_ff - NW'(1));
            state_in  = ST_LSUM_WAIT;
         end
         ST_LSUM_WAIT: begin
            if (mul_done) begin
               sum_in   = mul_p >> 1;
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            mul_start = 1'b1;
            mul_a     = 64'(laps_ff);
            mul_b     = sum_ff;
            state_in  = ST_TOTAL_WAIT;
         end
         ST_TOTAL_WAIT: begin
            if (mul_done) begin
               sum_in   = mul_p;
               idx_in   = '0;
               state_in = ST_CHASE_RD;
            end
         end
         ST_CHASE_RD: begin
            ra = idx_ff;
            if (rest_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_CHASE_ACC;
            end
         end
         ST_CHASE_ACC: begin
            // advance one load and accumulate it
            idx_in   = rd_a_ff;
            sum_in   = sum_ff + 64'(rd_a_ff);
            rest_in  = rest_ff - NW'(1);
            state_in = ST_CHASE_RD;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, idx32[FINAL_W-1:0], sum_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ncount_ff    <= NCOUNT_W'(4096);
         seed_ff      <= 64'd42;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_NODE_COUNT: ncount_ff <= csr_data[NCOUNT_W-1:0];
               REG_SEED_VALUE: seed_ff   <= csr_data;
               default: ;
            endcase
         end
      end
      n_ff        <= n_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      rng_ff      <= rng_in;
      laps_ff     <= laps_in;
      rest_ff     <= rest_in;
      sum_ff      <= sum_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // node table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_a_ff <= mem[ra];
      rd_b_ff <= mem[rb];
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

// File: design/scpc_mul.sv
// Iterative 64x64 multiplier, low 64 bits, one 16-bit digit per cycle.
module scpc_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] p_ff, p_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [79:0] partial;

   always_comb begin
      partial = a_ff * b_ff[15:0];
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         p_in    = 64'd0;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add one digit row, then move to the next digit
         p_in   = p_ff + partial[63:0];
         a_in   = {a_ff[47:0], 16'd0};
         b_in   = {16'd0, b_ff[63:16]};
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff;
endmodule

// File: design/scpc_div.sv
// Restoring radix-2 divider: 64-bit dividend, narrow divisor, one bit per cycle.
module scpc_div #(
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [63:0]   quotient,
   output logic [DW-1:0] remainder
);
   logic [63:0]   q_ff, q_in;
   logic [DW-1:0] r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   always_comb begin
      trial   = {r_ff, q_ff[63]};
      diff    = trial - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = 6'd63;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = diff[DW-1:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial[DW-1:0];
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;
endmodule
